[hw/rtl/rrsp_pkg.sv]
// Shared types and constants for the replay record stream parser.
// Used by rrsp_parser and replay_record_stream_parser; no dependencies.
package rrsp_pkg;

  // Parse phases of the byte walker
  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_STR,
    PH_NUM,
    PH_STOP
  } phase_t;

  // File layout
  localparam logic [32:0] MIN_FILE_LEN = 33'd400;
  localparam logic [32:0] HDR_LEN_V0   = 33'd272;
  localparam logic [32:0] HDR_LEN_V1   = 33'd400;
  localparam logic [31:0] PLAYER_OFS_LO = 32'd268;
  localparam logic [31:0] PLAYER_OFS_HI = 32'd271;

  // Magic words, first file byte in the low byte
  localparam logic [31:0] SIG_V0 = 32'h3043_524B;
  localparam logic [31:0] SIG_V1 = 32'h3143_524B;

  // Record types
  localparam logic [7:0] REC_INPUT = 8'h12;
  localparam logic [7:0] REC_DROP  = 8'h14;
  localparam logic [7:0] REC_CHAT  = 8'h08;

  // Summary status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // What one parsed byte produces (besides zero fill)
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic        has_sum;
    logic [30:0] sum_frames;
    logic [30:0] sum_delays;
    logic [1:0]  sum_status;
  } parse_res_t;

endpackage

[hw/rtl/rrsp_parser.sv]
// Byte walker of the replay parser: header checks, record state and counters.
// Depends on rrsp_pkg; instantiated by replay_record_stream_parser.
module rrsp_parser #(
  parameter int MAX_PLAYERS = 4,
  parameter int PW = 3,
  parameter int FW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           byte_value,
  input  logic                 last_byte,
  input  logic [31:0]          file_length,
  output rrsp_pkg::parse_res_t res,
  output logic [PW-1:0]        players,
  output logic [FW-1:0]        fill_cnt
);
  import rrsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [1:0]  magic_r, magic_nxt;
  logic [31:0] pword_r, pword_nxt;
  logic [15:0] rec_len_r, rec_len_nxt;
  logic [15:0] data_left_r, data_left_nxt;
  logic [1:0]  nulls_r, nulls_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic        no_data_r, no_data_nxt;
  logic [30:0] frames_r, frames_nxt;
  logic [30:0] delays_r, delays_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [32:0] pos33;
  logic [32:0] len33;
  logic [32:0] hdr_len;
  logic [15:0] len_full;
  logic        parse_en;

  // Clamp the raw player word to 1..MAX_PLAYERS
  function automatic logic [PW-1:0] clamp_players(input logic [31:0] w);
    logic [PW-1:0] r;
    if (w == 32'd0 || w[31]) begin
      r = PW'(1);
    end else if (w > 32'(MAX_PLAYERS)) begin
      r = PW'(MAX_PLAYERS);
    end else begin
      r = w[PW-1:0];
    end
    return r;
  endfunction

  assign pos33    = {1'b0, pos_r};
  assign len33    = {1'b0, file_length};
  assign hdr_len  = magic_r[1] ? HDR_LEN_V1 : HDR_LEN_V0;
  assign len_full = {byte_value, rec_len_r[7:0]};
  assign parse_en = (len33 >= MIN_FILE_LEN) && (pos_r < file_length);

  // Next state and results for the byte on the input
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = (pos_r == '1) ? pos_r : pos_r + 32'd1;
    magic_nxt     = magic_r;
    pword_nxt     = pword_r;
    rec_len_nxt   = rec_len_r;
    data_left_nxt = data_left_r;
    nulls_nxt     = nulls_r;
    skip_nxt      = skip_r;
    no_data_nxt   = no_data_r;
    frames_nxt    = frames_r;
    delays_nxt    = delays_r;
    err_nxt       = err_r;
    res           = '0;
    fill_cnt      = '0;
    players       = '0;

    if (parse_en) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (pos_r < 32'd4) begin
            if (byte_value != SIG_V0[{pos_r[1:0], 3'b000} +: 8]) magic_nxt[0] = 1'b0;
            if (byte_value != SIG_V1[{pos_r[1:0], 3'b000} +: 8]) magic_nxt[1] = 1'b0;
          end
          if (pos_r >= 32'd3) begin
            if (magic_nxt == 2'b00) begin
              err_nxt   = STATUS_BAD_MAGIC;
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          if (pos_r >= PLAYER_OFS_LO && pos_r <= PLAYER_OFS_HI) begin
            pword_nxt = pword_r | ({24'd0, byte_value} << {pos_r[1:0], 3'b000});
          end
          if (pos33 + 33'd1 >= hdr_len) phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          priority if (pos33 + 33'd1 >= len33) begin
            phase_nxt = PH_STOP;
          end else if (byte_value == REC_INPUT) begin
            phase_nxt = (pos33 + 33'd3 > len33) ? PH_STOP : PH_LEN_LO;
          end else if (byte_value == REC_DROP) begin
            nulls_nxt = 2'd1;
            skip_nxt  = 3'd4;
            phase_nxt = PH_STR;
          end else if (byte_value == REC_CHAT) begin
            nulls_nxt = 2'd2;
            skip_nxt  = 3'd0;
            phase_nxt = PH_STR;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_LEN_LO: begin
          rec_len_nxt = {8'd0, byte_value};
          phase_nxt   = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rec_len_nxt = len_full;
          priority if (len_full == 16'd0) begin
            fill_cnt   = FW'({clamp_players(pword_r), 2'b00});
            frames_nxt = frames_r + 31'd1;
            if (no_data_r) delays_nxt = delays_r + 31'd1;
            phase_nxt  = PH_TYPE;
          end else if (pos33 + 33'd1 + {17'd0, len_full} > len33) begin
            phase_nxt = PH_STOP;
          end else begin
            no_data_nxt   = 1'b0;
            frames_nxt    = frames_r + 31'd1;
            data_left_nxt = len_full;
            phase_nxt     = PH_DATA;
          end
        end
        PH_DATA: begin
          res.has_data  = 1'b1;
          res.data_byte = byte_value;
          data_left_nxt = data_left_r - 16'd1;
          if (data_left_r == 16'd1) phase_nxt = PH_TYPE;
        end
        PH_STR: begin
          if (byte_value == 8'd0) begin
            nulls_nxt = nulls_r - 2'd1;
            if (nulls_r == 2'd1) phase_nxt = (skip_r != 3'd0) ? PH_NUM : PH_TYPE;
          end
        end
        PH_NUM: begin
          skip_nxt = skip_r - 3'd1;
          if (skip_r == 3'd1) phase_nxt = PH_TYPE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // Player count as it stands after this byte
    players = clamp_players(pword_nxt);

    // Close the file: report and start over
    if (last_byte) begin
      res.has_sum    = 1'b1;
      res.sum_frames = frames_nxt;
      res.sum_delays = delays_nxt;
      res.sum_status = (len33 < MIN_FILE_LEN) ? STATUS_SHORT : err_nxt;
      phase_nxt      = PH_MAGIC;
      pos_nxt        = '0;
      magic_nxt      = 2'b11;
      pword_nxt      = '0;
      rec_len_nxt    = '0;
      data_left_nxt  = '0;
      nulls_nxt      = '0;
      skip_nxt       = '0;
      no_data_nxt    = 1'b1;
      frames_nxt     = '0;
      delays_nxt     = '0;
      err_nxt        = STATUS_OK;
    end
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      pos_r       <= '0;
      magic_r     <= 2'b11;
      pword_r     <= '0;
      rec_len_r   <= '0;
      data_left_r <= '0;
      nulls_r     <= '0;
      skip_r      <= '0;
      no_data_r   <= 1'b1;
      frames_r    <= '0;
      delays_r    <= '0;
      err_r       <= STATUS_OK;
    end else if (take) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      magic_r     <= magic_nxt;
      pword_r     <= pword_nxt;
      rec_len_r   <= rec_len_nxt;
      data_left_r <= data_left_nxt;
      nulls_r     <= nulls_nxt;
      skip_r      <= skip_nxt;
      no_data_r   <= no_data_nxt;
      frames_r    <= frames_nxt;
      delays_r    <= delays_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

[hw/rtl/replay_record_stream_parser.sv]
// Top level of the replay record stream parser: config register, input
// handshake and result sequencing. Depends on rrsp_pkg and rrsp_parser.
//
// The block takes one file byte per cycle while in_stall is low and gives
// out the data bytes of input records, zero fill for empty input records and
// one summary item at the byte marked last. Write cfg_file_length before the
// file starts (the port is always ready). Most bytes yield zero or one result,
// so input and output run back to back. A zero-length input record yields
// players*4 fill items, one per cycle from the output register while out_stall
// is low, and holds in_stall high until the last is loaded into the output
// register; a last byte that also yields data or fill sends its summary after
// them. out_stall holds in_stall too. There is no clearing pass after reset.
module replay_record_stream_parser #(
  parameter int MAX_PLAYERS = 4,
  localparam int PW = $clog2(MAX_PLAYERS + 1),
  localparam int FW = $clog2(4 * MAX_PLAYERS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_file_length,
  // byte input
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte_value,
  input  logic          in_last_byte,
  // results
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_item_kind,
  output logic [7:0]    out_byte,
  output logic [30:0]   out_frame_total,
  output logic [30:0]   out_delay_total,
  output logic [1:0]    out_status_code,
  output logic [PW-1:0] out_players_used,
  output logic          out_run_end
);
  import rrsp_pkg::*;

  logic [31:0]   file_len_r;

  parse_res_t    res;
  logic [PW-1:0] players;
  logic [FW-1:0] fill_cnt;

  logic          out_free, more, take;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          kind_r, kind_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [30:0]   frames_r, frames_nxt;
  logic [30:0]   delays_r, delays_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [PW-1:0] players_r, players_nxt;
  logic          run_end_r, run_end_nxt;

  // pending part of a burst
  logic [FW-1:0] fill_left_r, fill_left_nxt;
  logic          sum_pend_r, sum_pend_nxt;
  logic [30:0]   sum_frames_r, sum_frames_nxt;
  logic [30:0]   sum_delays_r, sum_delays_nxt;
  logic [1:0]    sum_status_r, sum_status_nxt;
  logic [PW-1:0] burst_pl_r, burst_pl_nxt;

  // Hold the file length
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r <= '0;
    end else if (cfg_valid) begin
      file_len_r <= cfg_file_length;
    end
  end

  // Take a byte when the output register frees up and no burst remains
  assign out_free = !out_valid_r || !out_stall;
  assign more     = (fill_left_r != '0) || sum_pend_r;
  assign in_stall = !out_free || more;
  assign take     = in_valid && !in_stall;

  rrsp_parser #(
    .MAX_PLAYERS (MAX_PLAYERS),
    .PW          (PW),
    .FW          (FW)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .byte_value  (in_byte_value),
    .last_byte   (in_last_byte),
    .file_length (file_len_r),
    .res         (res),
    .players     (players),
    .fill_cnt    (fill_cnt)
  );

  // Sequence results: data or fill first, summary last
  always_comb begin
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    byte_nxt       = byte_r;
    frames_nxt     = frames_r;
    delays_nxt     = delays_r;
    status_nxt     = status_r;
    players_nxt    = players_r;
    run_end_nxt    = run_end_r;
    fill_left_nxt  = fill_left_r;
    sum_pend_nxt   = sum_pend_r;
    sum_frames_nxt = sum_frames_r;
    sum_delays_nxt = sum_delays_r;
    sum_status_nxt = sum_status_r;
    burst_pl_nxt   = burst_pl_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (more) begin
        out_valid_nxt = 1'b1;
        players_nxt   = burst_pl_r;
        if (fill_left_r != '0) begin
          kind_nxt      = KIND_DATA;
          byte_nxt      = 8'd0;
          frames_nxt    = '0;
          delays_nxt    = '0;
          status_nxt    = STATUS_OK;
          fill_left_nxt = fill_left_r - FW'(1);
          run_end_nxt   = (fill_left_r == FW'(1)) && !sum_pend_r;
        end else begin
          kind_nxt     = KIND_SUMMARY;
          byte_nxt     = 8'd0;
          frames_nxt   = sum_frames_r;
          delays_nxt   = sum_delays_r;
          status_nxt   = sum_status_r;
          sum_pend_nxt = 1'b0;
          run_end_nxt  = 1'b1;
        end
      end else if (take) begin
        burst_pl_nxt   = players;
        sum_frames_nxt = res.sum_frames;
        sum_delays_nxt = res.sum_delays;
        sum_status_nxt = res.sum_status;
        sum_pend_nxt   = res.has_sum;
        players_nxt    = players;
        priority if (res.has_data) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DATA;
          byte_nxt      = res.data_byte;
          frames_nxt    = '0;
          delays_nxt    = '0;
          status_nxt    = STATUS_OK;
          run_end_nxt   = !res.has_sum;
        end else if (fill_cnt != '0) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DATA;
          byte_nxt      = 8'd0;
          frames_nxt    = '0;
          delays_nxt    = '0;
          status_nxt    = STATUS_OK;
          fill_left_nxt = fill_cnt - FW'(1);
          run_end_nxt   = (fill_cnt == FW'(1)) && !res.has_sum;
        end else if (res.has_sum) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SUMMARY;
          byte_nxt      = 8'd0;
          frames_nxt    = res.sum_frames;
          delays_nxt    = res.sum_delays;
          status_nxt    = res.sum_status;
          sum_pend_nxt  = 1'b0;
          run_end_nxt   = 1'b1;
        end else begin
          out_valid_nxt = 1'b0;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fill_left_r <= '0;
      sum_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      fill_left_r <= fill_left_nxt;
      sum_pend_r  <= sum_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    byte_r       <= byte_nxt;
    frames_r     <= frames_nxt;
    delays_r     <= delays_nxt;
    status_r     <= status_nxt;
    players_r    <= players_nxt;
    run_end_r    <= run_end_nxt;
    sum_frames_r <= sum_frames_nxt;
    sum_delays_r <= sum_delays_nxt;
    sum_status_r <= sum_status_nxt;
    burst_pl_r   <= burst_pl_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_byte         = byte_r;
  assign out_frame_total  = frames_r;
  assign out_delay_total  = delays_r;
  assign out_status_code  = status_r;
  assign out_players_used = players_r;
  assign out_run_end      = run_end_r;

endmodule
